FILE: rtl/core/mau_pkg.sv
// Package: shared types and constants of the matrix arithmetic unit.
`timescale 1ns / 1ps
package mau_pkg;
  localparam int DATA_W = 32;
  localparam int DIM_W  = 4;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_EMUL = 3'd2, OP_ADDS = 3'd3,
    OP_SUBS = 3'd4, OP_SCALE = 3'd5, OP_MATMUL = 3'd6, OP_TRANS = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    OPC_LOAD_A = 2'd0, OPC_LOAD_B = 2'd1, OPC_COMPUTE = 2'd2, OPC_NONE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_OPERATION = 3'd0, CFG_ROWS_A = 3'd1, CFG_COLS_A = 3'd2,
    CFG_ROWS_B = 3'd3, CFG_COLS_B = 3'd4, CFG_SCALAR = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_DRAIN
  } bk_state_t;

  // Command handed from the front to the back through the queue.
  typedef struct packed {
    logic        is_load;
    logic        sel_b;
    logic [DATA_W-1:0] value;
  } cmd_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [47:0] x);
    if (x > 48'sh0000_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (x < -48'sh0000_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = x[DATA_W-1:0];
  endfunction
endpackage

FILE: rtl/core/mau_if.sv
// Interfaces: valid/ready channels for input, result and configuration.
`timescale 1ns / 1ps
interface mau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic signed [31:0] value;
  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

interface mau_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value_res;
  logic        last;
  logic        error;
  modport source (output valid, value_res, last, error, input ready);
  modport sink   (input valid, value_res, last, error, output ready);
endinterface

interface mau_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/mau_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/mau_front.sv
// Front end: accepts input transactions, drops unused opcodes, queues commands.
`timescale 1ns / 1ps
module mau_front #(
  parameter int QDEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  mau_in_if.sink in_ch,
  output logic                 q_valid,
  input  logic                 q_pop,
  output mau_pkg::cmd_t        q_head
);
  import mau_pkg::*;
  localparam int PW = $clog2(QDEPTH);
  cmd_t q_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic push;
  cmd_t cmd;

  assign in_ch.ready = (cnt_r != QDEPTH[PW:0]);
  assign push = in_ch.valid && in_ch.ready && (in_ch.opcode != OPC_NONE);
  assign cmd.is_load = (in_ch.opcode != OPC_COMPUTE);
  assign cmd.sel_b = (in_ch.opcode == OPC_LOAD_B);
  assign cmd.value = in_ch.value;
  assign q_valid = (cnt_r != '0);
  assign q_head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cmd;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule

FILE: rtl/core/mau_back.sv
// Back end: matrix stores, element sequencer, arithmetic pipe and output skid.
`timescale 1ns / 1ps
module mau_back #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  mau_pkg::cmd_t        q_head,
  input  logic [2:0]           operation,
  input  logic [3:0]           rows_a, cols_a, rows_b, cols_b,
  input  logic signed [31:0]   scalar,
  mau_out_if.source out_ch
);
  import mau_pkg::*;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(MAX_DIM + 1);

  function automatic logic [CW-1:0] dimf(input logic [3:0] r);
    if (r == 4'd0) dimf = CW'(1);
    else if (r > 4'(MAX_DIM)) dimf = CW'(MAX_DIM);
    else dimf = r[CW-1:0];
  endfunction

  logic [CW-1:0] ra, ca, rb, cb;
  assign ra = dimf(rows_a); assign ca = dimf(cols_a);
  assign rb = dimf(rows_b); assign cb = dimf(cols_b);
  logic [AW:0] size_a, size_b;
  assign size_a = (AW+1)'(ra * ca);
  assign size_b = (AW+1)'(rb * cb);

  // Load indices.
  logic [AW:0] aidx_r, bidx_r, lidx, lsize, lnext;
  assign lsize = q_head.sel_b ? size_b : size_a;
  always_comb begin
    lidx = q_head.sel_b ? bidx_r : aidx_r;
    if (lidx >= lsize) lidx = '0;
    lnext = lidx + 1'b1;
    if (lnext >= lsize) lnext = '0;
  end

  bk_state_t st_r, st_nxt;
  logic [CW-1:0] i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [2:0] op_r;
  logic pipe_stall, issue, issue_last, issue_first, issue_err;
  logic load_now, cmd_start;

  // RAM addressing.
  logic [AW-1:0] a_raddr, b_raddr;
  logic [AW-1:0] a_hold_r, b_hold_r;  // last issued addresses, replayed on stall
  logic signed [31:0] a_q, b_q;
  logic [AW-1:0] waddr;
  assign waddr = lidx[AW-1:0];
  mau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (.clk(clk),
    .we(load_now && !q_head.sel_b), .waddr(waddr), .wdata(q_head.value),
    .raddr(a_raddr), .rdata(a_q));
  mau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (.clk(clk),
    .we(load_now && q_head.sel_b), .waddr(waddr), .wdata(q_head.value),
    .raddr(b_raddr), .rdata(b_q));

  logic is_mm, is_tr, ew_err, mm_err;
  assign is_mm = (op_r == OP_MATMUL);
  assign is_tr = (op_r == OP_TRANS);
  always_comb begin
    a_raddr = AW'(i_r * ca + j_r);
    b_raddr = AW'(i_r * ca + j_r);
    if (is_mm) begin
      a_raddr = AW'(i_r * ca + k_r);
      b_raddr = AW'(k_r * cb + j_r);
    end else if (is_tr) begin
      a_raddr = AW'(j_r * ca + i_r);
    end
    // Keep stage 1 read data in place while the pipe is held.
    if (pipe_stall) begin
      a_raddr = a_hold_r;
      b_raddr = b_hold_r;
    end
  end

  // Pipeline: s1 (ram read) -> s2 (mul/add) -> s3 (shift/sat, accumulate) -> skid
  logic v1_r, l1_r, f1_r, e1_r, kl1_r;
  logic v2_r, l2_r, f2_r, e2_r, kl2_r;
  logic signed [31:0] a2_r;
  logic signed [63:0] p2_r;
  logic signed [47:0] acc_r;
  logic ov_r;   // output register
  logic signed [31:0] ov_val_r; logic ov_last_r, ov_err_r;
  logic sk_r;   // skid register
  logic signed [31:0] sk_val_r; logic sk_last_r, sk_err_r;
  logic kend;

  assign pipe_stall = sk_r;
  assign kend = is_mm ? (k_r == ca - 1'b1) : 1'b1;

  // Sequencer.
  logic [CW-1:0] outer_n, inner_n;
  always_comb begin
    outer_n = is_tr ? ca : ra;
    inner_n = (is_mm) ? cb : (is_tr ? ra : ca);
  end
  assign ew_err = (ra != rb) || (ca != cb);
  assign mm_err = (ca != rb);

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    q_pop = 1'b0; load_now = 1'b0; cmd_start = 1'b0;
    issue = 1'b0; issue_err = 1'b0; issue_first = 1'b0; issue_last = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.is_load) begin
            q_pop = 1'b1; load_now = 1'b1;
          end else if (!pipe_stall) begin
            q_pop = 1'b1; cmd_start = 1'b1;
            i_nxt = '0; j_nxt = '0; k_nxt = '0; st_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!pipe_stall) begin
          issue = 1'b1;
          issue_first = (k_r == '0);
          if (((op_r == OP_ADD) || (op_r == OP_SUB) || (op_r == OP_EMUL)) && ew_err ||
              is_mm && mm_err) begin
            issue_err = 1'b1; issue_last = 1'b1; st_nxt = ST_DRAIN;
          end else if (!kend) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (j_r == inner_n - 1'b1) begin
              j_nxt = '0;
              if (i_r == outer_n - 1'b1) begin
                issue_last = 1'b1; st_nxt = ST_DRAIN;
              end else i_nxt = i_r + 1'b1;
            end else j_nxt = j_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !pipe_stall) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Stage 2 arithmetic.
  logic signed [31:0] opnd_b;
  logic signed [47:0] sum2;
  assign opnd_b = ((op_r == OP_ADD) || (op_r == OP_SUB) || (op_r == OP_EMUL) ||
                   is_mm) ? b_q : scalar;
  always_comb begin
    if ((op_r == OP_SUB) || (op_r == OP_SUBS)) sum2 = 48'(a_q) - 48'(opnd_b);
    else sum2 = 48'(a_q) + 48'(opnd_b);
  end
  logic signed [31:0] sum_sat_r;

  // Stage 3: shift, saturate, accumulate.
  logic signed [63:0] shp;
  logic signed [31:0] prod_sat, res3;
  logic signed [47:0] acc_nxt;
  always_comb begin
    shp = p2_r >>> FRAC_BITS;
    if (shp > 64'sh7FFF_FFFF) prod_sat = 32'sh7FFF_FFFF;
    else if (shp < -64'sh8000_0000) prod_sat = 32'sh8000_0000;
    else prod_sat = shp[31:0];
    acc_nxt = (f2_r ? 48'sd0 : acc_r) + 48'(prod_sat);
    case (op_r)
      OP_EMUL, OP_SCALE: res3 = prod_sat;
      OP_MATMUL:         res3 = sat32(acc_nxt);
      OP_TRANS:          res3 = a2_r;
      default:           res3 = sum_sat_r;
    endcase
    if (e2_r) res3 = '0;
  end
  logic emit3;
  assign emit3 = v2_r && kl2_r && !pipe_stall;

  logic out_take;
  assign out_take = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd_start) op_r <= q_head.is_load ? op_r : operation;
    if (issue) begin
      a_hold_r <= a_raddr; b_hold_r <= b_raddr;
    end
    if (!pipe_stall) begin
      l2_r <= l1_r; f2_r <= f1_r; e2_r <= e1_r; kl2_r <= kl1_r;
      a2_r <= a_q;
      p2_r <= 64'(a_q) * 64'(opnd_b);
      sum_sat_r <= sat32(sum2);
      l1_r <= issue_last; f1_r <= issue_first; e1_r <= issue_err;
      kl1_r <= kend || issue_err;
    end
    if (v2_r && !pipe_stall) acc_r <= acc_nxt;
    if (emit3 && (ov_r && !out_ch.ready)) begin
      sk_val_r <= res3; sk_last_r <= l2_r; sk_err_r <= e2_r;
    end
    if (sk_r && out_ch.ready) begin
      ov_val_r <= sk_val_r; ov_last_r <= sk_last_r; ov_err_r <= sk_err_r;
    end else if (emit3 && (!ov_r || out_ch.ready)) begin
      ov_val_r <= res3; ov_last_r <= l2_r; ov_err_r <= e2_r;
    end
    if (!rst_n) begin
      st_r <= ST_IDLE; i_r <= '0; j_r <= '0; k_r <= '0;
      aidx_r <= '0; bidx_r <= '0;
      v1_r <= 1'b0; v2_r <= 1'b0; ov_r <= 1'b0; sk_r <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
      if (load_now && !q_head.sel_b) aidx_r <= lnext;
      if (load_now && q_head.sel_b)  bidx_r <= lnext;
      if (cmd_start) begin aidx_r <= '0; bidx_r <= '0; end
      if (!pipe_stall) begin v1_r <= issue; v2_r <= v1_r; end
      if (sk_r) begin
        if (out_ch.ready) sk_r <= 1'b0;
      end else if (emit3 && ov_r && !out_ch.ready) sk_r <= 1'b1;
      if (sk_r) ov_r <= 1'b1;
      else if (emit3) ov_r <= 1'b1;
      else if (out_take) ov_r <= 1'b0;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.value_res = ov_val_r;
  assign out_ch.last = ov_last_r;
  assign out_ch.error = ov_err_r;
endmodule

FILE: rtl/core/matrix_arithmetic_unit.sv
// Top level of the matrix arithmetic unit.
`timescale 1ns / 1ps
// Matrix engine on signed fixed-point values (Q16.16 by default).
// Channels: in_ (opcode, value) valid/ready, out_ (value_res, last, error)
// valid/ready, cfg_ (index, data) register writes, always ready.
// Load transactions write the next element of A or B in row-major order,
// one per cycle while no compute runs. A compute transaction streams the
// configured operation's result row-major, last marked; a size mismatch
// yields one error result.
// Results: one per cycle for element-wise, scalar and transpose while the
// receiver keeps up; matmul sums cols_a products per result (one
// multiply-accumulate per cycle through the shared product stage).
// A two-entry command queue decouples intake from the back-end sequencer,
// which handles one compute at a time; loads behind it wait in the queue.
// Reset: control state, load indices and registers go to defaults; the
// matrix stores hold undefined data until loaded.
// Receiver stall: results park in the output and skid registers; the
// sequencer halts until space frees, nothing is dropped.
module matrix_arithmetic_unit #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  mau_in_if.sink    in_ch,
  mau_out_if.source out_ch,
  mau_cfg_if.sink   cfg_ch
);
  import mau_pkg::*;

  logic [2:0]  operation_r;
  logic [3:0]  rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic signed [31:0] scalar_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r <= OP_ADD;
      rows_a_r <= 4'd8; cols_a_r <= 4'd8; rows_b_r <= 4'd8; cols_b_r <= 4'd8;
      scalar_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_OPERATION: operation_r <= cfg_ch.data[2:0];
        CFG_ROWS_A:    rows_a_r <= cfg_ch.data[3:0];
        CFG_COLS_A:    cols_a_r <= cfg_ch.data[3:0];
        CFG_ROWS_B:    rows_b_r <= cfg_ch.data[3:0];
        CFG_COLS_B:    cols_b_r <= cfg_ch.data[3:0];
        CFG_SCALAR:    scalar_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic q_valid, q_pop;
  cmd_t q_head;

  mau_front #(.QDEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head));

  mau_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .operation(operation_r), .rows_a(rows_a_r), .cols_a(cols_a_r),
    .rows_b(rows_b_r), .cols_b(cols_b_r), .scalar(scalar_r), .out_ch(out_ch));
endmodule

FILE: rtl/core/mau_checker.sv
// Checker: port-level properties of the matrix arithmetic unit, bound to the top.
`timescale 1ns / 1ps
module mau_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid, out_ready, out_last, out_error,
  input logic [31:0] out_value_res
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res))
    else $error("result changed while stalled");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error result without last");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_value_res == 32'd0)
    else $error("error result not zero");
endmodule

bind matrix_arithmetic_unit mau_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.last), .out_error(out_ch.error),
  .out_value_res(out_ch.value_res));

FILE: sim/tb_matrix_arithmetic_unit.sv
// Testbench for matrix_arithmetic_unit: self-checking random and directed run.
`timescale 1ns / 1ps
module tb_matrix_arithmetic_unit;
  import mau_pkg::*;

  localparam int IDLE_LIMIT = 4000;  // cycles without any transaction
  localparam int HOLD_LEN   = 300;   // long receiver hold-off
  localparam int SETTLE     = 24;    // pipeline + command queue drain

  typedef struct {
    logic [1:0]         opc;
    logic signed [31:0] val;
  } item_t;

  typedef struct {
    logic signed [31:0] val;
    logic               last;
    logic               err;
  } elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mau_in_if  in_bus();
  mau_out_if out_bus();
  mau_cfg_if cfg_bus();

  matrix_arithmetic_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the unit: registers, stores and load pointers.
  op_t                sh_op;
  logic [3:0]         sh_ra, sh_ca, sh_rb, sh_cb;
  logic signed [31:0] sh_scalar;
  logic signed [31:0] mat_a [64];
  logic signed [31:0] mat_b [64];
  int                 a_ptr, b_ptr;

  item_t pending_items[$];
  elem_t expected_elems[$];

  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_idle = 0;   // percent of cycles the receiver holds back
  bit stall_req = 1'b0;
  bit stall_done = 1'b0;
  int hold_cnt = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int random_items = 0;
  item_t cur_item;

  function automatic int eff_dim(logic [3:0] r);
    if (r == 0) return 1;
    if (r > 8) return 8;
    return int'(r);
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Q16.16 product, floor shift (arithmetic shift on a signed 64-bit value)
  function automatic logic signed [31:0] fx_mul(logic signed [31:0] x,
                                                logic signed [31:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return clamp32(p >>> 16);
  endfunction

  function automatic void push_elem(logic signed [31:0] v, bit last, bit err);
    elem_t e;
    e.val = v;
    e.last = last;
    e.err = err;
    expected_elems.push_back(e);
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [31:0] d);
    case (idx)
      CFG_OPERATION: sh_op = op_t'(d[2:0]);
      CFG_ROWS_A:    sh_ra = d[3:0];
      CFG_COLS_A:    sh_ca = d[3:0];
      CFG_ROWS_B:    sh_rb = d[3:0];
      CFG_COLS_B:    sh_cb = d[3:0];
      CFG_SCALAR:    sh_scalar = d;
      default: ;
    endcase
  endfunction

  // Expected behavior of one accepted input transaction.
  function automatic void predict_matrix_op(item_t it);
    int ra, ca, rb, cb, n, pos;
    longint acc;
    logic signed [31:0] r;
    ra = eff_dim(sh_ra);
    ca = eff_dim(sh_ca);
    rb = eff_dim(sh_rb);
    cb = eff_dim(sh_cb);
    case (opcode_t'(it.opc))
      OPC_LOAD_A: begin
        if (a_ptr >= ra * ca) a_ptr = 0;
        mat_a[a_ptr] = it.val;
        a_ptr++;
        if (a_ptr >= ra * ca) a_ptr = 0;
      end
      OPC_LOAD_B: begin
        if (b_ptr >= rb * cb) b_ptr = 0;
        mat_b[b_ptr] = it.val;
        b_ptr++;
        if (b_ptr >= rb * cb) b_ptr = 0;
      end
      OPC_COMPUTE: begin
        a_ptr = 0;
        b_ptr = 0;
        case (sh_op)
          OP_ADD, OP_SUB, OP_EMUL: begin
            if (ra != rb || ca != cb) begin
              push_elem(0, 1'b1, 1'b1);
            end else begin
              n = ra * ca;
              for (int k = 0; k < n; k++) begin
                if (sh_op == OP_ADD) r = clamp32(longint'(mat_a[k]) + longint'(mat_b[k]));
                else if (sh_op == OP_SUB) r = clamp32(longint'(mat_a[k]) - longint'(mat_b[k]));
                else r = fx_mul(mat_a[k], mat_b[k]);
                push_elem(r, k + 1 == n, 1'b0);
              end
            end
          end
          OP_ADDS, OP_SUBS, OP_SCALE: begin
            n = ra * ca;
            for (int k = 0; k < n; k++) begin
              if (sh_op == OP_ADDS) r = clamp32(longint'(mat_a[k]) + longint'(sh_scalar));
              else if (sh_op == OP_SUBS) r = clamp32(longint'(mat_a[k]) - longint'(sh_scalar));
              else r = fx_mul(mat_a[k], sh_scalar);
              push_elem(r, k + 1 == n, 1'b0);
            end
          end
          OP_MATMUL: begin
            if (ca != rb) begin
              push_elem(0, 1'b1, 1'b1);
            end else begin
              n = ra * cb;
              for (int i = 0; i < ra; i++)
                for (int j = 0; j < cb; j++) begin
                  acc = 0;
                  for (int k = 0; k < ca; k++)
                    acc += longint'(fx_mul(mat_a[i * ca + k], mat_b[k * cb + j]));
                  pos = i * cb + j;
                  push_elem(clamp32(acc), pos + 1 == n, 1'b0);
                end
            end
          end
          default: begin  // transpose of A
            n = ra * ca;
            for (int i = 0; i < ca; i++)
              for (int j = 0; j < ra; j++) begin
                pos = i * ra + j;
                push_elem(mat_a[j * ca + i], pos + 1 == n, 1'b0);
              end
          end
        endcase
      end
      default: ;  // unused opcode: ignored by the unit
    endcase
  endfunction

  // Driver: one transaction in flight, next one picked once the current is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_matrix_op(cur_item);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_item = pending_items.pop_front();
          in_bus.valid  <= 1'b1;
          in_bus.opcode <= cur_item.opc;
          in_bus.value  <= cur_item.val;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Monitor: checks every result transaction, paces ready.
  always @(posedge clk) begin
    elem_t e;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_elems.size() == 0) begin
          note_mismatch($sformatf("unexpected result value=%h last=%b error=%b",
                                  out_bus.value_res, out_bus.last, out_bus.error));
        end else begin
          e = expected_elems.pop_front();
          if (out_bus.value_res !== e.val || out_bus.last !== e.last ||
              out_bus.error !== e.err)
            note_mismatch($sformatf("exp value=%h last=%b error=%b, got value=%h last=%b error=%b",
                                    e.val, e.last, e.err,
                                    out_bus.value_res, out_bus.last, out_bus.error));
        end
      end
      // A single long hold-off lets the sender back the unit up.
      if (stall_req && !stall_done) begin
        hold_cnt = HOLD_LEN;
        stall_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(opcode_t opc, logic [31:0] v);
    item_t it;
    it.opc = opc;
    it.val = v;
    pending_items.push_back(it);
  endtask

  // Blocks until the unit has nothing left to do; sampled mid-cycle so the
  // driver's updates of the same edge are already visible.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_bus.valid || expected_elems.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] d);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_reg(idx, d);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_cfg(op_t op, int ra, int ca, int rb, int cb, logic [31:0] sc);
    wait_quiet();
    cfg_write(CFG_OPERATION, 32'(op));
    cfg_write(CFG_ROWS_A, 32'(ra));
    cfg_write(CFG_COLS_A, 32'(ca));
    cfg_write(CFG_ROWS_B, 32'(rb));
    cfg_write(CFG_COLS_B, 32'(cb));
    cfg_write(CFG_SCALAR, sc);
  endtask

  // Mix of saturation corners, small Q16.16 values and raw random words.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 16)) - 8) * 32'h1_0000 +
                      32'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Random sizes stay within 3x3 so reads never pass the preloaded words.
  function automatic int rand_dim();
    int pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  task automatic set_mode(int s_idle, int r_idle);
    @(posedge clk);
    send_idle <= s_idle;
    recv_idle <= r_idle;
  endtask

  initial begin
    int ra, ca, rb, cb, na, nb, opv;
    in_bus.valid = 1'b0;
    in_bus.opcode = OPC_NONE;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_OPERATION;
    cfg_bus.data = '0;
    sh_op = OP_ADD;
    sh_ra = 8; sh_ca = 8; sh_rb = 8; sh_cb = 8;
    sh_scalar = 0;
    a_ptr = 0;
    b_ptr = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(20, 87);
    // Fill the first nine words of both stores; no later read goes past them.
    set_cfg(OP_ADD, 3, 3, 3, 3, 0);
    for (int k = 0; k < 9; k++) push_item(OPC_LOAD_A, $urandom());
    for (int k = 0; k < 9; k++) push_item(OPC_LOAD_B, $urandom());

    // Directed: corners through every operation on a 2x3 set.
    set_cfg(OP_ADD, 2, 3, 2, 3, 0);
    push_item(OPC_LOAD_A, 32'h7FFF_FFFF); push_item(OPC_LOAD_A, 32'h8000_0000);
    push_item(OPC_LOAD_A, 32'h0);         push_item(OPC_LOAD_A, 32'h1);
    push_item(OPC_LOAD_A, 32'hFFFF_FFFF); push_item(OPC_LOAD_A, 32'h1_0000);
    push_item(OPC_LOAD_B, 32'h7FFF_FFFF); push_item(OPC_LOAD_B, 32'h8000_0000);
    push_item(OPC_LOAD_B, 32'h8000_0000); push_item(OPC_LOAD_B, 32'hFFFF_FFFF);
    push_item(OPC_LOAD_B, 32'h1);         push_item(OPC_LOAD_B, 32'h1_0000);
    push_item(OPC_COMPUTE, 32'hFFFF_FFFF);
    set_cfg(OP_SUB, 2, 3, 2, 3, 0);              push_item(OPC_COMPUTE, 0);
    set_cfg(OP_EMUL, 2, 3, 2, 3, 0);             push_item(OPC_COMPUTE, 0);
    set_cfg(OP_ADDS, 2, 3, 2, 3, 32'h7FFF_FFFF); push_item(OPC_COMPUTE, 0);
    set_cfg(OP_SUBS, 2, 3, 2, 3, 32'h8000_0000); push_item(OPC_COMPUTE, 0);
    set_cfg(OP_SCALE, 2, 3, 2, 3, 32'h8000_0000); push_item(OPC_COMPUTE, 0);
    set_cfg(OP_MATMUL, 2, 3, 3, 2, 0);           push_item(OPC_COMPUTE, 0);
    set_cfg(OP_TRANS, 2, 3, 2, 3, 0);            push_item(OPC_COMPUTE, 0);
    // Size mismatches give a single error result.
    set_cfg(OP_ADD, 2, 3, 3, 2, 0);              push_item(OPC_COMPUTE, 0);
    set_cfg(OP_MATMUL, 2, 3, 2, 3, 0);           push_item(OPC_COMPUTE, 0);
    // Out-of-range dimensions clamp (0 -> 1, 15 -> 8); unused opcode ignored.
    set_cfg(OP_TRANS, 0, 15, 15, 0, 0);
    push_item(OPC_NONE, 32'hFFFF_FFFF);
    push_item(OPC_COMPUTE, 0);
    // Pointer left past the new size restarts; loads past the end wrap.
    set_cfg(OP_ADD, 2, 3, 2, 3, 0);
    for (int k = 0; k < 4; k++) push_item(OPC_LOAD_A, rand_word());
    set_cfg(OP_EMUL, 1, 2, 1, 2, 32'h1_0000);
    for (int k = 0; k < 3; k++) push_item(OPC_LOAD_A, rand_word());
    for (int k = 0; k < 2; k++) push_item(OPC_LOAD_B, rand_word());
    push_item(OPC_COMPUTE, 0);

    // Random: well-formed load/compute sequences with some noise.
    while (random_items < 40) begin
      if (random_items >= 13 && send_idle == 20) set_mode(87, 20);
      else if (random_items >= 27 && send_idle == 87) set_mode(0, 0);
      opv = $urandom_range(0, 7);
      ra = rand_dim(); ca = rand_dim(); rb = rand_dim(); cb = rand_dim();
      if ($urandom_range(0, 9) < 8) begin
        if (op_t'(opv) == OP_MATMUL) rb = ca;
        else begin rb = ra; cb = ca; end
      end
      set_cfg(op_t'(opv), ra, ca, rb, cb, rand_word());
      na = eff_dim(4'(ra)) * eff_dim(4'(ca));
      nb = eff_dim(4'(rb)) * eff_dim(4'(cb));
      if ($urandom_range(0, 6) == 0) na += $urandom_range(1, 3);
      if ($urandom_range(0, 6) == 0) na = $urandom_range(0, na);
      while (na > 0 || nb > 0) begin
        if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
          push_item(OPC_LOAD_A, rand_word()); na--;
        end else begin
          push_item(OPC_LOAD_B, rand_word()); nb--;
        end
        random_items++;
        if ($urandom_range(0, 19) == 0) push_item(OPC_NONE, $urandom());
      end
      push_item(OPC_COMPUTE, $urandom());
      random_items++;
    end

    // Back-pressure: long receiver hold-off while computes and loads pile up.
    set_cfg(OP_ADD, 3, 3, 3, 3, 0);
    @(posedge clk);
    stall_req <= 1'b1;
    push_item(OPC_COMPUTE, 0);
    for (int k = 0; k < 5; k++) push_item(OPC_LOAD_A, rand_word());
    push_item(OPC_COMPUTE, 0);
    for (int k = 0; k < 3; k++) push_item(OPC_LOAD_B, rand_word());
    push_item(OPC_COMPUTE, 0);

    wait_quiet();
    if (mismatches == 0 && expected_elems.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/mau_pkg.sv
rtl/core/mau_if.sv
rtl/core/mau_ram.sv
rtl/core/mau_front.sv
rtl/core/mau_back.sv
rtl/core/matrix_arithmetic_unit.sv
rtl/core/mau_checker.sv
sim/tb_matrix_arithmetic_unit.sv
